@@ design/finite_difference_derivative_defines.svh @@
// Assertion macros shared by the derivative block.
// FDD_ASSERT checks a condition in the same cycle, FDD_ASSERT_NEXT in the next cycle.
`ifndef FINITE_DIFFERENCE_DERIVATIVE_DEFINES_SVH
`define FINITE_DIFFERENCE_DERIVATIVE_DEFINES_SVH

`ifndef SYNTH
`define FDD_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FDD_ASSERT(label, clk, rst, ante, cons, msg)
`define FDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ design/fdd_pkg.sv @@
package fdd_pkg;

  // Kind of one derivative result.
  typedef enum logic [1:0] {
    OP_SHORT,
    OP_DIFF,
    OP_HALF,
    OP_FOURTH
  } op_t;

  // Which result of a queued entry is issued next.
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_MID,
    PH_TAIL
  } phase_t;

  // Control part of one queued entry.
  typedef struct packed {
    op_t  op;
    logic mid;
    logic tail;
  } entry_ctrl_t;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [2:0] POS_MAX = 3'd5;

endpackage

@@ design/finite_difference_derivative.sv @@
// Channel   Direction  Fields (lowest bit first)
// s_*       in         tdata: sample; tlast: frame_end
// m_*       out        tdata: slope; tlast: last_result; tuser: short_frame
// order_*   in         order_mode_we / order_mode_wdata, write only
//
// One sample can be taken every cycle while the result queue has room.
// Results leave at one per cycle while m_tready is high; an interior sample
// makes one result and a frame's last sample up to three, which the four-entry
// result queue absorbs. An entry at the queue head is issued into the stages
// s1 to s5 (divide by three: multiply by reciprocal, then correct, per term).
// Reset is synchronous and active high; it clears the order register, the frame
// position, the sample history, the queue and the pipeline valids, and holds
// s_tready low.
// A stall on the result side freezes the whole back pipeline; the input side
// keeps taking samples until the queue is full.
module finite_difference_derivative import fdd_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,

  // Slave side: tdata = sample, zero padding above it.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
  input  logic                                s_tlast,

  // Master side: tdata = slope, zero padding above it; tuser = short_frame.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
  output logic                                m_tlast,
  output logic                                m_tuser,

  // Stencil order register: 0 for second order, 1 for fourth order.
  input  logic                                order_mode_we,
  input  logic                                order_mode_wdata
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int TW    = ((SAMPLE_WIDTH+7)/8)*8;
  localparam int CTW   = $bits(entry_ctrl_t);
  localparam int QW    = CTW + 4*(SW+1);

  logic          accept;
  logic          push;
  logic          full;
  entry_ctrl_t   front_ctrl;
  logic [SW:0]   front_p;
  logic [SW:0]   front_q;
  logic [SW:0]   front_m;
  logic [SW:0]   front_e;
  logic          head_valid;
  logic [QW-1:0] head;
  entry_ctrl_t   head_ctrl;
  logic          pop;
  logic [SW-1:0] slope;

  // The slave side is ready (s_tready) whenever the queue has a free entry
  // and reset is low.
  assign s_tready = !full && !rst;
  assign accept   = s_tvalid && s_tready;

  fdd_front #(
    .SW(SW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (order_mode_we),
    .cfg_wdata (order_mode_wdata),
    .accept    (accept),
    .sample    (s_tdata[SW-1:0]),
    .frame_end (s_tlast),
    .push      (push),
    .ctrl      (front_ctrl),
    .op_p      (front_p),
    .op_q      (front_q),
    .op_m      (front_m),
    .op_e      (front_e)
  );

  fdd_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wdata      ({front_ctrl, front_p, front_q, front_m, front_e}),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  assign head_ctrl = head[QW-1 -: CTW];

  fdd_back #(
    .SW(SW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_ctrl   (head_ctrl),
    .head_p      (head[4*(SW+1)-1 -: SW+1]),
    .head_q      (head[3*(SW+1)-1 -: SW+1]),
    .head_m      (head[2*(SW+1)-1 -: SW+1]),
    .head_e      (head[SW:0]),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .slope       (slope),
    .last_result (m_tlast),
    .short_frame (m_tuser)
  );

  // The slope sits in the low bits; padding bits are driven to zero.
  assign m_tdata = TW'(slope);

endmodule

@@ design/fdd_front.sv @@
module fdd_front import fdd_pkg::*; #(
  parameter int SW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          accept,
  input  logic [SW-1:0] sample,
  input  logic          frame_end,
  output logic          push,
  output entry_ctrl_t   ctrl,
  output logic [SW:0]   op_p,
  output logic [SW:0]   op_q,
  output logic [SW:0]   op_m,
  output logic [SW:0]   op_e
);

  logic          order_mode;
  logic          frame_order;
  logic [2:0]    position;
  logic [SW-1:0] history [4];
  logic          fo;
  logic          need;

  function automatic logic [SW:0] sub(input logic [SW-1:0] a, input logic [SW-1:0] b);
    sub = {a[SW-1], a} - {b[SW-1], b};
  endfunction

  assign fo = (position == 3'd0) ? order_mode : frame_order;

  always_comb begin
    ctrl.op   = OP_SHORT;
    ctrl.mid  = 1'b0;
    ctrl.tail = 1'b0;
    op_p      = '0;
    op_q      = '0;
    op_m      = sub(sample, history[1]);
    op_e      = sub(sample, history[0]);
    need      = frame_end;
    if (!fo) begin
      if (position != 3'd0) begin
        need      = 1'b1;
        ctrl.tail = frame_end;
        if (position == 3'd1) begin
          ctrl.op = OP_DIFF;
          op_p    = sub(sample, history[0]);
        end else begin
          ctrl.op = OP_HALF;
          op_p    = sub(sample, history[1]);
        end
      end
    end else begin
      if (position >= 3'd2) begin
        need      = 1'b1;
        ctrl.mid  = frame_end;
        ctrl.tail = frame_end;
        if (position == 3'd2) begin
          ctrl.op = OP_DIFF;
          op_p    = sub(history[0], history[1]);
        end else if (position == 3'd3) begin
          ctrl.op = OP_HALF;
          op_p    = sub(history[0], history[2]);
        end else begin
          ctrl.op = OP_FOURTH;
          op_p    = sub(history[0], history[2]);
          op_q    = sub(history[3], sample);
        end
      end
    end
  end

  assign push = accept && need;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode  <= 1'b0;
      frame_order <= 1'b0;
      position    <= 3'd0;
      for (int i = 0; i < 4; i++) begin
        history[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        order_mode <= cfg_wdata;
      end
      if (accept) begin
        frame_order <= fo;
        history[0]  <= sample;
        for (int i = 1; i < 4; i++) begin
          history[i] <= history[i-1];
        end
        if (frame_end) begin
          position <= 3'd0;
        end else if (position < POS_MAX) begin
          position <= position + 3'd1;
        end
      end
    end
  end

endmodule

@@ design/fdd_queue.sv @@
module fdd_queue import fdd_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ design/fdd_back.sv @@
`include "finite_difference_derivative_defines.svh"

module fdd_back import fdd_pkg::*; #(
  parameter int SW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  entry_ctrl_t   head_ctrl,
  input  logic [SW:0]   head_p,
  input  logic [SW:0]   head_q,
  input  logic [SW:0]   head_m,
  input  logic [SW:0]   head_e,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [SW-1:0] slope,
  output logic          last_result,
  output logic          short_frame
);

  localparam logic [SW:0]   FULL   = (SW+1)'(1) << SW;
  localparam logic [SW-1:0] RECIP3 = SW'(FULL / (SW+1)'(3));
  localparam logic [SW-1:0] THREE  = SW'(3);
  localparam logic [SW-1:0] SMAX   = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMIN   = {1'b1, {(SW-1){1'b0}}};

  logic   en;
  logic   issue;
  phase_t phase;
  phase_t phase_next;
  op_t    sel_op;
  logic [SW:0] sel_p;
  logic [SW:0] sel_q;
  logic   sel_last;
  logic   sel_end;

  // Stage 1: selected operands.
  logic        s1_valid;
  op_t         s1_op;
  logic [SW:0] s1_p;
  logic [SW:0] s1_q;
  logic        s1_last;
  // Stage 2: magnitudes and the simple results.
  logic          s2_valid;
  op_t           s2_op;
  logic          s2_last;
  logic [SW-1:0] s2_mag_b;
  logic [SW-1:0] s2_mag_c;
  logic          s2_neg_b;
  logic          s2_neg_c;
  logic [SW+1:0] s2_simple;
  // Stage 3: first quotient estimate of b.
  logic          s3_valid;
  op_t           s3_op;
  logic          s3_last;
  logic [SW-1:0] s3_mag_b;
  logic [SW-1:0] s3_mag_c;
  logic          s3_neg_b;
  logic          s3_neg_c;
  logic [SW+1:0] s3_simple;
  logic [SW-1:0] s3_est_b;
  // Stage 4: corrected b quotient, estimate of c.
  logic          s4_valid;
  op_t           s4_op;
  logic          s4_last;
  logic [SW-1:0] s4_mag_c;
  logic          s4_neg_b;
  logic          s4_neg_c;
  logic [SW+1:0] s4_simple;
  logic [SW-1:0] s4_quo_b;
  logic [SW-1:0] s4_est_c;
  // Stage 5: output register.
  logic          s5_valid;
  logic [SW-1:0] s5_slope;
  logic          s5_last;
  logic          s5_short;

  logic [SW:0]     p_ext_abs;
  logic [SW:0]     q_ext_abs;
  logic [SW+1:0]   p_wide;
  logic [SW+1:0]   half_sum;
  logic [2*SW-1:0] prod_b;
  logic [2*SW-1:0] prod_c;
  logic [SW-1:0]   rem_b;
  logic [SW-1:0]   rem_c;
  logic [SW-1:0]   quo_c;
  logic [SW+1:0]   term_b;
  logic [SW+1:0]   term_c;
  logic [SW+1:0]   value;

  assign en    = !s5_valid || out_ready;
  assign issue = head_valid && en;
  assign pop   = issue && sel_end;

  // Next phase of the entry sequencer.
  always_comb begin
    phase_next = phase;
    if (issue) begin
      if (sel_end) begin
        phase_next = PH_FIRST;
      end else begin
        unique case (phase)
          PH_FIRST: phase_next = head_ctrl.mid ? PH_MID : PH_TAIL;
          PH_MID:   phase_next = PH_TAIL;
          default:  phase_next = PH_FIRST;
        endcase
      end
    end
  end

  // Result selected for the current phase.
  always_comb begin
    sel_op   = head_ctrl.op;
    sel_p    = head_p;
    sel_q    = head_q;
    sel_last = (head_ctrl.op == OP_SHORT);
    sel_end  = 1'b1;
    unique case (phase)
      PH_FIRST: begin
        sel_end = !head_ctrl.mid && !head_ctrl.tail;
      end
      PH_MID: begin
        sel_op  = OP_HALF;
        sel_p   = head_m;
        sel_end = !head_ctrl.tail;
        sel_last = 1'b0;
      end
      PH_TAIL: begin
        sel_op   = OP_DIFF;
        sel_p    = head_e;
        sel_last = 1'b1;
      end
      default: begin
        sel_end = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
    end else begin
      phase <= phase_next;
    end
  end

  // Stage 2 datapath.
  assign p_ext_abs = s1_p[SW] ? -s1_p : s1_p;
  assign q_ext_abs = s1_q[SW] ? -s1_q : s1_q;
  assign p_wide    = {s1_p[SW], s1_p};
  assign half_sum  = p_wide + {{(SW+1){1'b0}}, s1_p[SW]};

  // Divide by three: estimate by reciprocal, then one correction step.
  assign prod_b = {{SW{1'b0}}, s2_mag_b} * {{SW{1'b0}}, RECIP3};
  assign prod_c = {{SW{1'b0}}, s3_mag_c} * {{SW{1'b0}}, RECIP3};
  assign rem_b  = s3_mag_b - {s3_est_b[SW-2:0], 1'b0} - s3_est_b;
  assign rem_c  = s4_mag_c - {s4_est_c[SW-2:0], 1'b0} - s4_est_c;
  assign quo_c  = s4_est_c + ((rem_c >= THREE) ? SW'(1) : SW'(0));

  assign term_b = s4_neg_b ? -{1'b0, s4_quo_b, 1'b0} : {1'b0, s4_quo_b, 1'b0};
  assign term_c = s4_neg_c ? -{2'b00, quo_c} : {2'b00, quo_c};
  assign value  = (s4_op == OP_FOURTH) ? (term_b + term_c) : s4_simple;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op   <= sel_op;
      s1_p    <= sel_p;
      s1_q    <= sel_q;
      s1_last <= sel_last;

      s2_op    <= s1_op;
      s2_last  <= s1_last;
      s2_mag_b <= p_ext_abs[SW-1:0];
      s2_mag_c <= {2'b00, q_ext_abs[SW-1:2]};
      s2_neg_b <= s1_p[SW];
      s2_neg_c <= s1_q[SW];
      unique case (s1_op)
        OP_DIFF:   s2_simple <= p_wide;
        OP_HALF:   s2_simple <= {half_sum[SW+1], half_sum[SW+1:1]};
        OP_SHORT:  s2_simple <= '0;
        OP_FOURTH: s2_simple <= '0;
      endcase

      s3_op     <= s2_op;
      s3_last   <= s2_last;
      s3_mag_b  <= s2_mag_b;
      s3_mag_c  <= s2_mag_c;
      s3_neg_b  <= s2_neg_b;
      s3_neg_c  <= s2_neg_c;
      s3_simple <= s2_simple;
      s3_est_b  <= prod_b[2*SW-1:SW];

      s4_op     <= s3_op;
      s4_last   <= s3_last;
      s4_mag_c  <= s3_mag_c;
      s4_neg_b  <= s3_neg_b;
      s4_neg_c  <= s3_neg_c;
      s4_simple <= s3_simple;
      s4_quo_b  <= s3_est_b + ((rem_b >= THREE) ? SW'(1) : SW'(0));
      s4_est_c  <= prod_c[2*SW-1:SW];

      s5_last  <= s4_last;
      s5_short <= (s4_op == OP_SHORT);
      if ((value[SW+1:SW-1] == 3'b000) || (value[SW+1:SW-1] == 3'b111)) begin
        s5_slope <= value[SW-1:0];
      end else begin
        s5_slope <= value[SW+1] ? SMIN : SMAX;
      end
    end
  end

  assign out_valid   = s5_valid;
  assign slope       = s5_slope;
  assign last_result = s5_last;
  assign short_frame = s5_short;

  `FDD_ASSERT(a_pop_needs_entry, clk, rst, pop, head_valid, "pop from an empty queue")
  `FDD_ASSERT(a_mid_phase_flag, clk, rst, head_valid && (phase == PH_MID), head_ctrl.mid, "middle result issued for an entry without one")
  `FDD_ASSERT(a_short_is_final, clk, rst, s5_valid && s5_short, s5_last && (s5_slope == '0), "short-frame result must be last and zero")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

// Testbench for the streaming finite-difference derivative.
// Samples go in on the slave stream and derivative results come out on the
// master stream. A predictor kept in this module works out the results of every
// accepted sample transfer and queues them. The checker compares each accepted
// result transfer with the oldest queued result.
module tb_top import fdd_pkg::*; ();

  localparam int SW = 16;
  localparam int DW = ((SW + 7) / 8) * 8;

  // Stencil order codes as the order register sees them.
  localparam logic ORDER2 = 1'b0;
  localparam logic ORDER4 = 1'b1;

  // Cycles allowed after the last expected result before a register write or
  // the end of the run. The block has a short pipeline, and fourth-order
  // frames can hold samples that have not yet produced any result.
  localparam int SETTLE_CYCLES = 16;
  // A long output hold-off, long enough to fill the result queue.
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 300000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic          s_tlast = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic          m_tlast;
  logic          m_tuser;
  logic          order_mode_we = 1'b0;
  logic          order_mode_wdata = 1'b0;

  finite_difference_derivative #(.SAMPLE_WIDTH(SW)) DUT (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .m_tuser          (m_tuser),
    .order_mode_we    (order_mode_we),
    .order_mode_wdata (order_mode_wdata)
  );

  // One derivative result as it should leave the block.
  typedef struct {
    logic signed [SW-1:0] slope;
    logic                 last;
    logic                 is_short;
  } slope_rec_t;

  slope_rec_t expected_slopes[$];

  // Predictor state: the last four samples, the frame position, the order
  // register and the order latched at the first sample of the current frame.
  logic signed [SW-1:0] hist[4] = '{default: '0};
  logic [2:0]           pos = '0;
  logic                 order_reg = ORDER2;
  logic                 frame_order = ORDER2;

  // Traffic shaping, changed by the tests between phases.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;

  int  errors = 0;
  int  samples_sent = 0;
  int  results_checked = 0;
  int  cycles = 0;

  initial begin
    forever begin
      #1 clk = ~clk;
    end
  end

  // Saturate an exact intermediate value to the sample range.
  function automatic logic signed [SW-1:0] clamp_sample(int v);
    int hi;
    int lo;
    hi = (1 << (SW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[SW-1:0];
  endfunction

  function automatic void push_slope(int v, logic last, logic shrt);
    slope_rec_t rec;
    rec.slope = shrt ? '0 : clamp_sample(v);
    rec.last = last;
    rec.is_short = shrt;
    expected_slopes.push_back(rec);
  endfunction

  // Work out the results that one accepted sample causes and update the
  // predictor state. Integer division in SystemVerilog truncates toward zero,
  // which is what the stencils call for.
  function automatic void predict_slopes(logic signed [SW-1:0] smp, logic last);
    int x;
    int h0;
    int h1;
    int h2;
    int h3;
    x = smp;
    h0 = hist[0];
    h1 = hist[1];
    h2 = hist[2];
    h3 = hist[3];
    // The order is latched when a frame starts, so a register write in the
    // middle of a frame only affects the next frame.
    if (pos == 3'd0) frame_order = order_reg;
    if (frame_order == ORDER2) begin
      if (pos == 3'd0) begin
        // A one-sample frame gives a single result marked as short.
        if (last) push_slope(0, 1'b1, 1'b1);
      end else begin
        if (pos == 3'd1) push_slope(x - h0, 1'b0, 1'b0);
        else push_slope((x - h1) / 2, 1'b0, 1'b0);
        if (last) push_slope(x - h0, 1'b1, 1'b0);
      end
    end else begin
      if (pos < 3'd2) begin
        // Frames of one or two samples are too short for the wide stencil.
        if (last) push_slope(0, 1'b1, 1'b1);
      end else begin
        // Results lag by two samples: this one is for position pos - 2.
        if (pos == 3'd2) push_slope(h0 - h1, 1'b0, 1'b0);
        else if (pos == 3'd3) push_slope((h0 - h2) / 2, 1'b0, 1'b0);
        else push_slope(((h0 - h2) / 3) * 2 + (h3 - x) / 12, 1'b0, 1'b0);
        // The last sample flushes the two pending end points.
        if (last) begin
          push_slope((x - h1) / 2, 1'b0, 1'b0);
          push_slope(x - h0, 1'b1, 1'b0);
        end
      end
    end
    hist[3] = hist[2];
    hist[2] = hist[1];
    hist[1] = hist[0];
    hist[0] = smp;
    if (last) pos = 3'd0;
    else if (pos < POS_MAX) pos = pos + 3'd1;
  endfunction

  // Offer one sample. Entered and left just after a falling edge. The valid
  // line is left high after the transfer, so that back-to-back samples never
  // see it lowered and raised in the same time step.
  task automatic send_sample(logic signed [SW-1:0] smp, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DW'(smp);
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    predict_slopes(smp, last);
    samples_sent++;
    @(negedge clk);
  endtask

  // Stop offering samples and wait until every expected result has arrived,
  // then let the pipeline settle. Leaves just after a falling edge.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_slopes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the order register while the block is idle.
  task automatic set_order(logic mode);
    wait_drained();
    order_mode_we <= 1'b1;
    order_mode_wdata <= mode;
    @(negedge clk);
    order_mode_we <= 1'b0;
    order_reg = mode;
  endtask

  // Mostly full-range values, with the extremes and small values mixed in
  // so that ties, odd differences and truncation of negatives come up.
  function automatic logic signed [SW-1:0] pick_sample();
    logic [SW-1:0] raw;
    raw = SW'($urandom);
    unique case ($urandom_range(9))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2, 3, 4: return SW'($signed($urandom_range(40)) - 20);
      default: return raw;
    endcase
  endfunction

  // Frame lengths: mostly short, a few long enough to saturate the position.
  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(2, 1);
    if (r < 85) return $urandom_range(10, 3);
    return $urandom_range(30, 11);
  endfunction

  task automatic send_frame(int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // Receiver: ready changes at the falling edge. A hold-off request keeps it
  // low for a long stretch counted here.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker: every result transfer is matched against the oldest
  // expected result, all three fields at once.
  initial begin
    slope_rec_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (expected_slopes.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: slope %0d last %0b short %0b",
                   $time, $signed(m_tdata[SW-1:0]), m_tlast, m_tuser);
        end else begin
          want = expected_slopes.pop_front();
          results_checked++;
          if (m_tdata !== DW'(want.slope) || m_tlast !== want.last ||
              m_tuser !== want.is_short) begin
            errors++;
            $display("%0t: expected slope/last/short %0d/%0b/%0b, got %0d/%0b/%0b",
                     $time, want.slope, want.last, want.is_short,
                     $signed(m_tdata[SW-1:0]), m_tlast, m_tuser);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycles,
             expected_slopes.size());
    $display("tb: failure");
    $finish;
  end

  // Frames too short for the stencil, and the shortest frames that are not:
  // two samples for second order, three for fourth order.
  task automatic test_short_frames();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_order(ORDER2);
    send_sample(16'sh7fff, 1'b1);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd4, 1'b1);
    set_order(ORDER4);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd101, 1'b1);
    send_sample(16'sd7, 1'b0);
    send_sample(-16'sd6, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  // Full-scale swings, so that end points and the wide stencil saturate.
  task automatic test_saturation();
    set_order(ORDER2);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd1, 1'b1);
    set_order(ORDER4);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
  endtask

  // A write to the order register in the middle of a frame takes effect with
  // the next frame only.
  task automatic test_order_change_mid_frame();
    set_order(ORDER2);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd9, 1'b0);
    send_sample(16'sd20, 1'b0);
    set_order(ORDER4);
    send_sample(-16'sd13, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd30, 1'b1);
    send_frame(5);
  endtask

  // Random frames under each mix of sender idling and receiver stalls, in
  // both orders.
  task automatic test_random_traffic();
    int idle_mix[4];
    int stall_mix[4];
    int target;
    idle_mix = '{0, 73, 0, 34};
    stall_mix = '{0, 0, 73, 34};
    for (int p = 0; p < 8; p++) begin
      set_order(p[0] ? ORDER4 : ORDER2);
      send_idle_pct = idle_mix[p / 2];
      recv_stall_pct = stall_mix[p / 2];
      target = samples_sent + 24;
      while (samples_sent < target) send_frame(pick_frame_len());
    end
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so
  // the result queue fills and the input stalls. Then the sender pauses in the
  // middle of a frame until every result has arrived, and finishes the frame.
  task automatic test_backpressure();
    set_order(ORDER4);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    send_frame(3);
    send_frame(12);
    send_frame(2);
    for (int i = 0; i < 6; i++) send_sample(pick_sample(), 1'b0);
    wait_drained();
    for (int i = 0; i < 6; i++) send_sample(pick_sample(), i == 5);
    set_order(ORDER2);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    send_frame(20);
    send_frame(1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_short_frames();
    test_saturation();
    test_order_change_mid_frame();
    test_random_traffic();
    test_backpressure();
    wait_drained();

    $display("summary: %0d samples sent, %0d results checked in %0d cycles",
             samples_sent, results_checked, cycles);
    $display("summary: both orders, short frames, saturation, order change in a frame, stalls");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
